/* rtl/core/wbps_pkg.sv */
// Shared types and constants of the wildcard byte pattern search block.
package wbps_pkg;

	// Pattern storage and field widths
	localparam int PATTERN_BYTES = 16;
	localparam int MAX_PATTERN   = 16;
	localparam int BYTE_W        = 8;
	localparam int ADDR_W        = 48;
	localparam int LEN_W         = 5;
	localparam int MASK_W        = 16;
	localparam int IDX_W         = 4;
	localparam int CFG_DATA_W    = 64;
	localparam int PADDR_W       = 6;
	localparam int REG_SEL_W     = 3;

	// Register map, one 64-bit slot per register
	typedef enum logic [REG_SEL_W-1:0] {
		REG_PAT_LO = 3'd0,
		REG_PAT_HI = 3'd1,
		REG_MASK   = 3'd2,
		REG_LEN    = 3'd3,
		REG_START  = 3'd4
	} reg_idx_t;

	typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] pattern_t;

	// Control handed from the sequencer to every window cell
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	// One result word
	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] addr;
	} result_t;

endpackage

/* rtl/core/wbps_cell.sv */
// One window cell: holds one earlier byte, compares it with its pattern byte.
module wbps_cell #(
	parameter int K = 0
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  wbps_pkg::cell_ctl_t                      ctl,
	input  logic [wbps_pkg::LEN_W-1:0]               used_len,
	input  wbps_pkg::pattern_t                       pattern,
	input  logic [wbps_pkg::MASK_W-1:0]              mask,
	input  logic [wbps_pkg::BYTE_W-1:0]              byte_in,
	input  logic                                     valid_in,
	output logic [wbps_pkg::BYTE_W-1:0]              byte_out,
	output logic                                     valid_out,
	output logic                                     ok
);

	logic [wbps_pkg::BYTE_W-1:0] byte_q;
	logic                        valid_q;
	logic                        active;
	logic [wbps_pkg::LEN_W:0]    diff;
	logic [wbps_pkg::IDX_W-1:0]  pidx;

	// Stored byte shifts in from the newer neighbor
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= byte_in;
		end
	end

	// Valid marks a byte taken in the current range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= valid_in;
		end
	end

	// This cell holds the byte K+1 older than the newest; it lines up with
	// pattern byte used_len-2-K when the pattern reaches that far back
	always_comb begin
		active = {1'b0, used_len} >= (wbps_pkg::LEN_W+1)'(K + 2);
		diff   = {1'b0, used_len} - (wbps_pkg::LEN_W+1)'(K + 2);
		pidx   = diff[wbps_pkg::IDX_W-1:0];
		ok     = !active || (valid_q && (mask[pidx] || byte_q == pattern[pidx]));
	end

	assign byte_out  = byte_q;
	assign valid_out = valid_q;

endmodule

/* rtl/core/wbps_ctrl.sv */
// Scan sequencer: head compare, range offset, match state and address.
module wbps_ctrl #(
	parameter int P = wbps_pkg::PATTERN_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [wbps_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          last_byte,
	input  wbps_pkg::pattern_t            pattern,
	input  logic [wbps_pkg::MASK_W-1:0]   mask,
	input  logic [wbps_pkg::LEN_W-1:0]    len_cfg,
	input  logic [wbps_pkg::ADDR_W-1:0]   range_start,
	input  logic [P-1:0]                  cell_ok,
	output logic [wbps_pkg::LEN_W-1:0]    used_len,
	output wbps_pkg::cell_ctl_t           ctl,
	output logic                          push,
	output wbps_pkg::result_t             push_data
);

	localparam logic [wbps_pkg::LEN_W-1:0] PLEN = wbps_pkg::LEN_W'(P);

	logic [wbps_pkg::ADDR_W-1:0] offset_q;
	logic                        match_done_q;
	logic [wbps_pkg::LEN_W-1:0]  len_m1;
	logic [wbps_pkg::IDX_W-1:0]  head_idx;
	logic                        head_ok;
	logic                        hit;

	// Effective length, clamped to 1..P
	always_comb begin
		if (len_cfg == '0) begin
			used_len = wbps_pkg::LEN_W'(1);
		end else if (len_cfg > PLEN) begin
			used_len = PLEN;
		end else begin
			used_len = len_cfg;
		end
	end

	// Newest byte against the last pattern byte, then the whole window
	always_comb begin
		len_m1   = used_len - wbps_pkg::LEN_W'(1);
		head_idx = len_m1[wbps_pkg::IDX_W-1:0];
		head_ok  = mask[head_idx] || data_byte == pattern[head_idx];
		hit      = !match_done_q && head_ok && (&cell_ok);
	end

	// Step control
	always_comb begin
		ctl.shift = accept && !match_done_q && !last_byte;
		ctl.clear = accept && last_byte;
		push      = accept && !match_done_q && (hit || last_byte);
		push_data.found = hit;
		push_data.addr  = hit ? (range_start + offset_q
			- {{(wbps_pkg::ADDR_W-wbps_pkg::IDX_W){1'b0}}, head_idx}) : '0;
	end

	// Offset of the current byte in the range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (ctl.clear) begin
			offset_q <= '0;
		end else if (ctl.shift) begin
			offset_q <= offset_q + wbps_pkg::ADDR_W'(1);
		end
	end

	// Match reported: drop bytes until the range ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_done_q <= 1'b0;
		end else if (ctl.clear) begin
			match_done_q <= 1'b0;
		end else if (accept && hit) begin
			match_done_q <= 1'b1;
		end
	end

endmodule

/* rtl/core/wbps_obuf.sv */
// Result output register with a skid word behind it.
module wbps_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wbps_pkg::result_t push_data,
	input  logic              out_stall,
	output logic              out_valid,
	output wbps_pkg::result_t out_data,
	output logic              full
);

	logic              out_valid_q;
	logic              skid_valid_q;
	wbps_pkg::result_t out_q;
	wbps_pkg::result_t skid_q;
	logic              out_ready;

	assign out_ready = !out_valid_q || !out_stall;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload words
	always_ff @(posedge clk) begin
		if (out_ready) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign full      = skid_valid_q;

endmodule

/* rtl/core/wildcard_byte_pattern_search_top.sv */
// Top level of the wildcard byte pattern search block.
//
// Bytes of a memory range enter on the byte channel (data_byte, last_byte,
// byte_valid, byte_stall), one word per cycle. Each byte is compared
// against a window held in a chain of cells, one cell per pattern byte.
// A result word (found, match_address) leaves on the result channel
// (result_valid, result_stall): found=1 with the address of the first matched
// byte on the first match of a range, or found=0 when the range ends without
// one. After a match the rest of the range produces no word.
// The result word is registered, via the skid word while the output is held.
// Throughput: one byte per cycle while byte_stall is low, set by the combinational window compare.
// The result side has an output register and one skid word; byte_stall rises
// only while both are full, i.e. after the receiver has held result_stall
// with a second result pending.
// Registers are written over the APB port at 8*index: pattern bytes low and
// high, wildcard mask, pattern length and range start. Reset clears the scan
// state and sets the pattern length to 1, everything else to zero.
module wildcard_byte_pattern_search_top #(
	parameter int PATTERN_BYTES = wbps_pkg::PATTERN_BYTES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [wbps_pkg::PADDR_W-1:0]       paddr,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [wbps_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                               pready,
	// byte channel
	input  logic                               byte_valid,
	output logic                               byte_stall,
	input  logic [wbps_pkg::BYTE_W-1:0]        data_byte,
	input  logic                               last_byte,
	// result channel
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               found,
	output logic [wbps_pkg::ADDR_W-1:0]        match_address
);

	logic [wbps_pkg::CFG_DATA_W-1:0] pat_lo_q;
	logic [wbps_pkg::CFG_DATA_W-1:0] pat_hi_q;
	logic [wbps_pkg::MASK_W-1:0]     mask_q;
	logic [wbps_pkg::LEN_W-1:0]      len_q;
	logic [wbps_pkg::ADDR_W-1:0]     start_q;
	wbps_pkg::reg_idx_t              reg_sel;
	logic                            wr_en;

	wbps_pkg::pattern_t              pattern;
	logic [wbps_pkg::LEN_W-1:0]      used_len;
	wbps_pkg::cell_ctl_t             ctl;
	logic                            accept;
	logic                            push;
	wbps_pkg::result_t               push_data;
	wbps_pkg::result_t               out_data;

	logic [PATTERN_BYTES-1:0][wbps_pkg::BYTE_W-1:0] link_byte;
	logic [PATTERN_BYTES-1:0]                       link_valid;
	logic [PATTERN_BYTES-1:0]                       cell_ok;

	// Register access
	assign pready  = 1'b1;
	assign reg_sel = wbps_pkg::reg_idx_t'(paddr[wbps_pkg::PADDR_W-1:3]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			mask_q   <= '0;
			len_q    <= wbps_pkg::LEN_W'(1);
			start_q  <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				wbps_pkg::REG_PAT_LO: pat_lo_q <= pwdata;
				wbps_pkg::REG_PAT_HI: pat_hi_q <= pwdata;
				wbps_pkg::REG_MASK:   mask_q   <= pwdata[wbps_pkg::MASK_W-1:0];
				wbps_pkg::REG_LEN:    len_q    <= pwdata[wbps_pkg::LEN_W-1:0];
				wbps_pkg::REG_START:  start_q  <= pwdata[wbps_pkg::ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_sel)
			wbps_pkg::REG_PAT_LO: prdata = pat_lo_q;
			wbps_pkg::REG_PAT_HI: prdata = pat_hi_q;
			wbps_pkg::REG_MASK:   prdata = wbps_pkg::CFG_DATA_W'(mask_q);
			wbps_pkg::REG_LEN:    prdata = wbps_pkg::CFG_DATA_W'(len_q);
			wbps_pkg::REG_START:  prdata = wbps_pkg::CFG_DATA_W'(start_q);
			default:              prdata = '0;
		endcase
	end

	assign pattern = {pat_hi_q, pat_lo_q};
	assign accept  = byte_valid && !byte_stall;

	// Window chain: cell 0 takes the incoming byte, each cell feeds the next
	assign link_byte[0]  = data_byte;
	assign link_valid[0] = 1'b1;

	for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cell
		if (k < PATTERN_BYTES - 1) begin : g_mid
			wbps_cell #(.K(k)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.used_len  (used_len),
				.pattern   (pattern),
				.mask      (mask_q),
				.byte_in   (link_byte[k]),
				.valid_in  (link_valid[k]),
				.byte_out  (link_byte[k+1]),
				.valid_out (link_valid[k+1]),
				.ok        (cell_ok[k])
			);
		end else begin : g_end
			wbps_cell #(.K(k)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.used_len  (used_len),
				.pattern   (pattern),
				.mask      (mask_q),
				.byte_in   (link_byte[k]),
				.valid_in  (link_valid[k]),
				.byte_out  (),
				.valid_out (),
				.ok        (cell_ok[k])
			);
		end
	end

	// Sequencer
	wbps_ctrl #(.P(PATTERN_BYTES)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.pattern     (pattern),
		.mask        (mask_q),
		.len_cfg     (len_q),
		.range_start (start_q),
		.cell_ok     (cell_ok),
		.used_len    (used_len),
		.ctl         (ctl),
		.push        (push),
		.push_data   (push_data)
	);

	// Result buffer
	wbps_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.out_stall (result_stall),
		.out_valid (result_valid),
		.out_data  (out_data),
		.full      (byte_stall)
	);

	assign found         = out_data.found;
	assign match_address = out_data.addr;

endmodule

/* rtl/core/wbps_checker.sv */
// Port-level checks of the pattern search top level, bound to it.
module wbps_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         byte_stall,
	input logic                         result_valid,
	input logic                         result_stall,
	input logic                         found,
	input logic [wbps_pkg::ADDR_W-1:0]  match_address
);

	// A stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(found)
			&& $stable(match_address))
		else $error("result word changed while stalled");

	// No match carries a zero address
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found |-> match_address == '0)
		else $error("miss word with nonzero address");

	// Byte side stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> result_valid)
		else $error("byte stall without a pending result");

	// Skid word drains as soon as the receiver takes a word
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall && !result_stall |=> !byte_stall)
		else $error("byte stall held after result taken");

endmodule

bind wildcard_byte_pattern_search_top wbps_checker u_wbps_checker (.*);
